// ===== hdl/wsps_pkg.sv =====
// Shared types, constants and helpers for the wander steering particle step unit.
package wsps_pkg;

    localparam int DW           = 40;
    localparam int CORDIC_STEPS = 24;
    localparam int ZW           = 34;
    localparam int RW           = 25;
    localparam int IDXW         = 5;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [23:0] INV_GAIN     = 24'd10188013;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    localparam logic [23:0] MAX_SPEED_RST  = 24'd91750;
    localparam logic [23:0] WANDER_RAD_RST = 24'd1048576;
    localparam logic [23:0] WANDER_DST_RST = 24'd3932160;

    localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
    localparam logic [2:0] REG_WANDER_RAD  = 3'd1;
    localparam logic [2:0] REG_WANDER_DST  = 3'd2;
    localparam logic [2:0] REG_BOUND_LEFT  = 3'd3;
    localparam logic [2:0] REG_BOUND_TOP   = 3'd4;
    localparam logic [2:0] REG_BOUND_WIDTH = 3'd5;
    localparam logic [2:0] REG_BOUND_HGT   = 3'd6;

    localparam logic [1:0] FUNC_STEP    = 2'd0;
    localparam logic [1:0] FUNC_LOAD_P  = 2'd1;
    localparam logic [1:0] FUNC_LOAD_V  = 2'd2;
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    typedef enum logic {
        CM_ROTATE,
        CM_VECTOR
    } t_cordic_mode;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_PREP,
        CS_ITER,
        CS_MUL_LO,
        CS_MUL_HI,
        CS_DONE
    } t_cordic_state;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VEL_V,
        ST_VEL_R,
        ST_BOUND,
        ST_BOUND_V,
        ST_RAD_R,
        ST_TGT_V,
        ST_TGT_R,
        ST_STEER_V,
        ST_STEER_R,
        ST_NV,
        ST_NV_V,
        ST_NV_R,
        ST_UPD,
        ST_FINISH
    } t_seq_state;

    typedef struct packed {
        logic                  valid;
        t_cordic_mode          mode;
        logic signed [DW-1:0]  x;
        logic signed [DW-1:0]  y;
        logic [RW-1:0]         r;
        logic [31:0]           ang;
    } t_cordic_req;

    typedef struct packed {
        logic                  idle;
        logic                  done;
        logic signed [DW-1:0]  x;
        logic signed [DW-1:0]  y;
        logic signed [DW-1:0]  mag;
        logic [31:0]           ang;
    } t_cordic_rsp;

    function automatic logic [31:0] atan_turn(input logic [IDXW-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [DW-1:0] sext32(input logic [31:0] v);
        return {{(DW-32){v[31]}}, v};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [DW-1:0] v);
        logic [31:0] res;
        if (v > sext32(32'h7FFF_FFFF)) begin
            res = 32'h7FFF_FFFF;
        end else if (v < sext32(32'h8000_0000)) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/wsps_cordic.sv =====
// Iterative CORDIC: rotation and vectoring with a shared gain multiplier.
module wsps_cordic (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wsps_pkg::t_cordic_req  i_req,
    output wsps_pkg::t_cordic_rsp  o_rsp
);

    localparam int DW = wsps_pkg::DW;
    localparam int ZW = wsps_pkg::ZW;

    wsps_pkg::t_cordic_state r_state, n_state;
    wsps_pkg::t_cordic_mode  r_mode;
    logic signed [DW-1:0]    r_x, r_y, r_mag;
    logic signed [ZW-1:0]    r_z;
    logic [wsps_pkg::IDXW-1:0] r_i;
    logic [wsps_pkg::RW-1:0] r_r;
    logic [63:0]             r_acc;

    logic [wsps_pkg::RW-1:0] mul_a;
    logic [48:0]             mul_p;
    logic signed [DW-1:0]    dx, dy;
    logic signed [ZW-1:0]    at;
    logic [31:0]             qa;
    logic [63:0]             mag_sum;
    logic                    last_iter;

    assign mul_p     = mul_a * wsps_pkg::INV_GAIN;
    assign dx        = r_y >>> r_i;
    assign dy        = r_x >>> r_i;
    assign at        = ZW'(wsps_pkg::atan_turn(r_i));
    assign qa        = r_z[31:0] + wsps_pkg::QUARTER_TURN;
    assign mag_sum   = r_acc + {mul_p[43:0], 20'd0};
    assign last_iter = (r_i == wsps_pkg::IDXW'(wsps_pkg::CORDIC_STEPS - 1));

    always_comb begin
        case (r_state)
            wsps_pkg::CS_PREP:   mul_a = r_r;
            wsps_pkg::CS_MUL_LO: mul_a = {5'd0, r_x[19:0]};
            wsps_pkg::CS_MUL_HI: mul_a = {5'd0, r_x[39:20]};
            default:             mul_a = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wsps_pkg::CS_IDLE:   if (i_req.valid) begin
                n_state = wsps_pkg::CS_PREP;
            end
            wsps_pkg::CS_PREP:   n_state = wsps_pkg::CS_ITER;
            wsps_pkg::CS_ITER:   if (last_iter) begin
                n_state = (r_mode == wsps_pkg::CM_VECTOR) ? wsps_pkg::CS_MUL_LO
                                                          : wsps_pkg::CS_DONE;
            end
            wsps_pkg::CS_MUL_LO: n_state = wsps_pkg::CS_MUL_HI;
            wsps_pkg::CS_MUL_HI: n_state = wsps_pkg::CS_DONE;
            wsps_pkg::CS_DONE:   n_state = wsps_pkg::CS_IDLE;
            default:             n_state = wsps_pkg::CS_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.idle = (r_state == wsps_pkg::CS_IDLE);
        o_rsp.done = (r_state == wsps_pkg::CS_DONE);
        o_rsp.x    = r_x;
        o_rsp.y    = r_y;
        o_rsp.mag  = r_mag;
        o_rsp.ang  = r_z[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsps_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            wsps_pkg::CS_IDLE: begin
                r_mode <= i_req.mode;
                r_x    <= i_req.x;
                r_y    <= i_req.y;
                r_r    <= i_req.r;
                r_z    <= ZW'(i_req.ang);
                r_i    <= '0;
            end
            wsps_pkg::CS_PREP: begin
                if (r_mode == wsps_pkg::CM_ROTATE) begin
                    // fold the angle into the right half plane
                    r_y <= '0;
                    if (qa[31]) begin
                        r_x <= -DW'(mul_p[48:24]);
                        r_z <= {{(ZW-32){~r_z[31]}}, ~r_z[31], r_z[30:0]};
                    end else begin
                        r_x <= DW'(mul_p[48:24]);
                        r_z <= {{(ZW-32){r_z[31]}}, r_z[31:0]};
                    end
                end else begin
                    if (r_x < 0) begin
                        r_x <= -r_x;
                        r_y <= -r_y;
                        r_z <= ZW'(wsps_pkg::HALF_TURN);
                    end else begin
                        r_z <= '0;
                    end
                end
            end
            wsps_pkg::CS_ITER: begin
                r_i <= r_i + 1'b1;
                if (r_mode == wsps_pkg::CM_ROTATE) begin
                    if (!r_z[ZW-1]) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + at;
                    end
                end else begin
                    if (r_y > 0) begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + at;
                    end else begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - at;
                    end
                end
            end
            wsps_pkg::CS_MUL_LO: r_acc <= {15'd0, mul_p};
            wsps_pkg::CS_MUL_HI: r_mag <= mag_sum[63:24];
            default: ;
        endcase
    end

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !o_rsp.done)
        else $error("cordic done held for more than one cycle");

    a_vec_x_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wsps_pkg::CS_MUL_LO) |-> !r_x[DW-1])
        else $error("vectoring x negative before gain");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wsps_pkg::CS_PREP) |-> $past(r_state == wsps_pkg::CS_IDLE))
        else $error("cordic started outside idle");

endmodule

// ===== hdl/wander_steering_particle_step_unit.sv =====
// A load or unused func goes straight to the finish state, which registers the output beat.
// A step runs up to ten CORDIC passes, in rotate or vector mode, each through the
// 24-iteration CORDIC loop.
// One item at a time: the next item is taken once the previous one is finished.
// Reset (synchronous, active low) clears state to zero and registers to defaults.
// Top level: wander steering particle step with configuration registers.
module wander_steering_particle_step_unit #(
    parameter int ANGLE_BITS = wsps_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = wsps_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_value_x,
    input  logic signed [31:0] i_value_y,
    input  logic signed [13:0] i_theta_jitter,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x_out,
    output logic signed [31:0] o_pos_y_out,
    output logic signed [31:0] o_vel_x_out,
    output logic signed [31:0] o_vel_y_out,
    output logic               o_was_outside
);

    localparam int DW = wsps_pkg::DW;
    localparam int RW = wsps_pkg::RW;
    localparam logic [RW-1:0] EASE_NEAR = RW'(((2 ** FRAC_BITS) * 2 + 5) / 10);
    localparam logic [RW-1:0] EASE_FAR  = RW'(2 ** FRAC_BITS);
    localparam logic [32:0]   ROUND_ADD = 33'd1 << (31 - ANGLE_BITS);

    // configuration
    logic [23:0]        r_max_speed, r_wander_rad, r_wander_dst;
    logic [31:0]        r_bound_left, r_bound_top;
    logic [30:0]        r_bound_width, r_bound_hgt;

    // particle state and working registers
    wsps_pkg::t_seq_state  r_state, n_state;
    logic [31:0]           r_pos_x, r_pos_y, r_vel_x, r_vel_y;
    logic [ANGLE_BITS-1:0] r_angle;
    logic signed [DW-1:0]  r_cx, r_cy, r_sx, r_sy;
    logic [31:0]           r_cang;
    logic [RW-1:0]         r_ease;
    logic                  r_outside;
    logic                  r_wait;

    wsps_pkg::t_cordic_req c_req;
    wsps_pkg::t_cordic_rsp c_rsp;

    logic                  in_accept, out_free;
    logic signed [DW-1:0]  bnd_px, bnd_py, rad_sx, rad_sy, tgt_sx, tgt_sy, nv_sx, nv_sy;
    logic signed [DW-1:0]  upd_pos_x, upd_pos_y;
    logic [31:0]           upd_vel_x, upd_vel_y, jit_sum, theta;
    logic [32:0]           inward;
    logic                  vel_nz, mag_gt_width, mag_gt_ease, mag_gt_speed;

    wsps_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (c_req),
        .o_rsp   (c_rsp)
    );

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !o_out_valid || !i_out_stall;

    assign vel_nz  = (r_vel_x != '0) || (r_vel_y != '0);
    assign jit_sum = 32'(r_angle) + {{18{i_theta_jitter[13]}}, i_theta_jitter};
    assign theta   = 32'(r_angle) << (32 - ANGLE_BITS);
    assign inward  = {1'b0, c_rsp.ang + wsps_pkg::HALF_TURN} + ROUND_ADD;

    assign bnd_px = (r_cx <<< 1) - ((wsps_pkg::sext32(r_bound_left) <<< 1)
                    + DW'(r_bound_width));
    assign bnd_py = (r_cy <<< 1) - ((wsps_pkg::sext32(r_bound_top) <<< 1)
                    + DW'(r_bound_hgt));
    assign rad_sx = r_cx + c_rsp.x - wsps_pkg::sext32(r_pos_x);
    assign rad_sy = r_cy + c_rsp.y - wsps_pkg::sext32(r_pos_y);
    assign tgt_sx = c_rsp.x - wsps_pkg::sext32(r_vel_x);
    assign tgt_sy = c_rsp.y - wsps_pkg::sext32(r_vel_y);
    assign nv_sx  = wsps_pkg::sext32(r_vel_x) + r_sx;
    assign nv_sy  = wsps_pkg::sext32(r_vel_y) + r_sy;

    assign upd_vel_x = wsps_pkg::sat32(r_sx);
    assign upd_vel_y = wsps_pkg::sat32(r_sy);
    assign upd_pos_x = wsps_pkg::sext32(r_pos_x) + wsps_pkg::sext32(upd_vel_x);
    assign upd_pos_y = wsps_pkg::sext32(r_pos_y) + wsps_pkg::sext32(upd_vel_y);

    assign mag_gt_width = c_rsp.mag > DW'(r_bound_width);
    assign mag_gt_ease  = c_rsp.mag > DW'(r_ease);
    assign mag_gt_speed = c_rsp.mag > DW'(r_max_speed);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wsps_pkg::ST_IDLE: if (in_accept) begin
                if (i_func == wsps_pkg::FUNC_STEP) begin
                    n_state = vel_nz ? wsps_pkg::ST_VEL_V : wsps_pkg::ST_BOUND;
                end else begin
                    n_state = wsps_pkg::ST_FINISH;
                end
            end
            wsps_pkg::ST_VEL_V:   if (c_rsp.done) n_state = wsps_pkg::ST_VEL_R;
            wsps_pkg::ST_VEL_R:   if (c_rsp.done) n_state = wsps_pkg::ST_BOUND;
            wsps_pkg::ST_BOUND: begin
                n_state = ((bnd_px != '0) || (bnd_py != '0)) ? wsps_pkg::ST_BOUND_V
                                                             : wsps_pkg::ST_RAD_R;
            end
            wsps_pkg::ST_BOUND_V: if (c_rsp.done) n_state = wsps_pkg::ST_RAD_R;
            wsps_pkg::ST_RAD_R:   if (c_rsp.done) begin
                n_state = ((rad_sx != '0) || (rad_sy != '0)) ? wsps_pkg::ST_TGT_V
                                                             : wsps_pkg::ST_NV;
            end
            wsps_pkg::ST_TGT_V:   if (c_rsp.done) n_state = wsps_pkg::ST_TGT_R;
            wsps_pkg::ST_TGT_R:   if (c_rsp.done) begin
                n_state = ((tgt_sx != '0) || (tgt_sy != '0)) ? wsps_pkg::ST_STEER_V
                                                             : wsps_pkg::ST_NV;
            end
            wsps_pkg::ST_STEER_V: if (c_rsp.done) begin
                n_state = mag_gt_ease ? wsps_pkg::ST_STEER_R : wsps_pkg::ST_NV;
            end
            wsps_pkg::ST_STEER_R: if (c_rsp.done) n_state = wsps_pkg::ST_NV;
            wsps_pkg::ST_NV: begin
                n_state = ((nv_sx != '0) || (nv_sy != '0)) ? wsps_pkg::ST_NV_V
                                                           : wsps_pkg::ST_UPD;
            end
            wsps_pkg::ST_NV_V:    if (c_rsp.done) begin
                n_state = mag_gt_speed ? wsps_pkg::ST_NV_R : wsps_pkg::ST_UPD;
            end
            wsps_pkg::ST_NV_R:    if (c_rsp.done) n_state = wsps_pkg::ST_UPD;
            wsps_pkg::ST_UPD:     n_state = wsps_pkg::ST_FINISH;
            wsps_pkg::ST_FINISH:  if (out_free) n_state = wsps_pkg::ST_IDLE;
            default:              n_state = wsps_pkg::ST_IDLE;
        endcase
    end

    // outputs: stall and CORDIC request
    always_comb begin
        o_in_stall  = (r_state != wsps_pkg::ST_IDLE);
        c_req.valid = 1'b0;
        c_req.mode  = wsps_pkg::CM_VECTOR;
        c_req.x     = r_sx;
        c_req.y     = r_sy;
        c_req.r     = '0;
        c_req.ang   = r_cang;
        case (r_state)
            wsps_pkg::ST_VEL_V: begin
                c_req.valid = !r_wait;
                c_req.x     = wsps_pkg::sext32(r_vel_x);
                c_req.y     = wsps_pkg::sext32(r_vel_y);
            end
            wsps_pkg::ST_VEL_R: begin
                c_req.valid = !r_wait;
                c_req.mode  = wsps_pkg::CM_ROTATE;
                c_req.r     = RW'(r_wander_dst);
            end
            wsps_pkg::ST_BOUND_V, wsps_pkg::ST_TGT_V,
            wsps_pkg::ST_STEER_V, wsps_pkg::ST_NV_V: begin
                c_req.valid = !r_wait;
            end
            wsps_pkg::ST_RAD_R: begin
                c_req.valid = !r_wait;
                c_req.mode  = wsps_pkg::CM_ROTATE;
                c_req.r     = RW'(r_wander_rad);
                c_req.ang   = theta;
            end
            wsps_pkg::ST_TGT_R, wsps_pkg::ST_NV_R: begin
                c_req.valid = !r_wait;
                c_req.mode  = wsps_pkg::CM_ROTATE;
                c_req.r     = RW'(r_max_speed);
            end
            wsps_pkg::ST_STEER_R: begin
                c_req.valid = !r_wait;
                c_req.mode  = wsps_pkg::CM_ROTATE;
                c_req.r     = r_ease;
            end
            default: ;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed   <= wsps_pkg::MAX_SPEED_RST;
            r_wander_rad  <= wsps_pkg::WANDER_RAD_RST;
            r_wander_dst  <= wsps_pkg::WANDER_DST_RST;
            r_bound_left  <= '0;
            r_bound_top   <= '0;
            r_bound_width <= '0;
            r_bound_hgt   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                wsps_pkg::REG_MAX_SPEED:   r_max_speed   <= i_cfg_data[23:0];
                wsps_pkg::REG_WANDER_RAD:  r_wander_rad  <= i_cfg_data[23:0];
                wsps_pkg::REG_WANDER_DST:  r_wander_dst  <= i_cfg_data[23:0];
                wsps_pkg::REG_BOUND_LEFT:  r_bound_left  <= i_cfg_data;
                wsps_pkg::REG_BOUND_TOP:   r_bound_top   <= i_cfg_data;
                wsps_pkg::REG_BOUND_WIDTH: r_bound_width <= i_cfg_data[30:0];
                wsps_pkg::REG_BOUND_HGT:   r_bound_hgt   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // control and particle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wsps_pkg::ST_IDLE;
            r_wait      <= 1'b0;
            o_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_angle     <= '0;
        end else begin
            r_state <= n_state;
            if (c_req.valid) begin
                r_wait <= 1'b1;
            end else if (c_rsp.done) begin
                r_wait <= 1'b0;
            end
            if (out_free) begin
                o_out_valid <= (r_state == wsps_pkg::ST_FINISH);
            end
            if (in_accept) begin
                case (i_func)
                    wsps_pkg::FUNC_STEP:   r_angle <= jit_sum[ANGLE_BITS-1:0];
                    wsps_pkg::FUNC_LOAD_P: begin
                        r_pos_x <= i_value_x;
                        r_pos_y <= i_value_y;
                    end
                    wsps_pkg::FUNC_LOAD_V: begin
                        r_vel_x <= i_value_x;
                        r_vel_y <= i_value_y;
                    end
                    default: ;
                endcase
            end
            if ((r_state == wsps_pkg::ST_BOUND_V) && c_rsp.done && mag_gt_width) begin
                r_angle <= inward[31 -: ANGLE_BITS];
            end
            if (r_state == wsps_pkg::ST_UPD) begin
                r_vel_x <= upd_vel_x;
                r_vel_y <= upd_vel_y;
                r_pos_x <= wsps_pkg::sat32(upd_pos_x);
                r_pos_y <= wsps_pkg::sat32(upd_pos_y);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            wsps_pkg::ST_IDLE: begin
                r_cx      <= wsps_pkg::sext32(r_pos_x);
                r_cy      <= wsps_pkg::sext32(r_pos_y);
                r_ease    <= EASE_NEAR;
                r_outside <= 1'b0;
            end
            wsps_pkg::ST_VEL_V, wsps_pkg::ST_TGT_V: if (c_rsp.done) begin
                r_cang <= c_rsp.ang;
            end
            wsps_pkg::ST_VEL_R: if (c_rsp.done) begin
                r_cx <= r_cx + c_rsp.x;
                r_cy <= r_cy + c_rsp.y;
            end
            wsps_pkg::ST_BOUND: begin
                r_sx <= bnd_px;
                r_sy <= bnd_py;
            end
            wsps_pkg::ST_BOUND_V: if (c_rsp.done && mag_gt_width) begin
                r_ease    <= EASE_FAR;
                r_outside <= 1'b1;
            end
            wsps_pkg::ST_RAD_R: if (c_rsp.done) begin
                r_sx <= rad_sx;
                r_sy <= rad_sy;
            end
            wsps_pkg::ST_TGT_R: if (c_rsp.done) begin
                r_sx <= tgt_sx;
                r_sy <= tgt_sy;
            end
            wsps_pkg::ST_STEER_V, wsps_pkg::ST_NV_V: if (c_rsp.done) begin
                r_cang <= c_rsp.ang;
            end
            wsps_pkg::ST_STEER_R, wsps_pkg::ST_NV_R: if (c_rsp.done) begin
                r_sx <= c_rsp.x;
                r_sy <= c_rsp.y;
            end
            wsps_pkg::ST_NV: begin
                r_sx <= nv_sx;
                r_sy <= nv_sy;
            end
            default: ;
        endcase
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if ((r_state == wsps_pkg::ST_FINISH) && out_free) begin
            o_pos_x_out   <= r_pos_x;
            o_pos_y_out   <= r_pos_y;
            o_vel_x_out   <= r_vel_x;
            o_vel_y_out   <= r_vel_y;
            o_was_outside <= r_outside;
        end
    end

    a_req_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_req.valid |-> c_rsp.idle)
        else $error("cordic request while unit busy");

    a_beat_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == wsps_pkg::ST_FINISH))
        else $error("output beat without finished item");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("second item taken while first in flight");

    a_outside_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == wsps_pkg::ST_UPD) && r_outside) |-> (r_ease == EASE_FAR))
        else $error("outside step without full steering limit");

endmodule

// ===== tb/sv/wsps_checker.sv =====
`timescale 1ns / 1ps
// Beat monitor and prediction of the particle state for the wander steering step unit.
module wsps_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         func,
    input  logic signed [31:0] value_x,
    input  logic signed [31:0] value_y,
    input  logic signed [13:0] theta_jitter,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] pos_x_out,
    input  logic signed [31:0] pos_y_out,
    input  logic signed [31:0] vel_x_out,
    input  logic signed [31:0] vel_y_out,
    input  logic               was_outside,
    output int                 mismatches,
    output int                 pending,
    output int                 steps_seen,
    output int                 outside_seen
);

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               outside;
    } t_particle;

    localparam longint NEAR_LIMIT = ((longint'(1) << 16) * 2 + 5) / 10;
    localparam longint FAR_LIMIT  = longint'(1) << 16;
    localparam longint GAIN_INV   = 10188013;

    bit [31:0] arc_tab [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Register and particle copies
    bit [23:0]          max_spd, wnd_rad, wnd_dst;
    logic signed [31:0] b_left, b_top;
    bit [30:0]          b_width, b_height;
    longint             p_x, p_y, v_x, v_y;
    bit [15:0]          w_ang;

    t_particle expected_q [$];

    function automatic void rotate_vec(input longint r, input bit [31:0] a,
                                       output longint ox, output longint oy);
        longint x, y, z, dx, dy;
        bit [31:0] aa;
        x  = (r * GAIN_INV) >>> 24;
        y  = 0;
        aa = a;
        if (((aa + wsps_pkg::QUARTER_TURN) & wsps_pkg::HALF_TURN) != 0) begin
            x  = -x;
            aa = aa + wsps_pkg::HALF_TURN;
        end
        z = longint'($signed(aa));
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(arc_tab[i]);
            end else begin
                x += dx; y -= dy; z += longint'(arc_tab[i]);
            end
        end
        ox = x;
        oy = y;
    endfunction

    function automatic void measure_vec(input longint xi, input longint yi,
                                        output longint mag, output bit [31:0] ang);
        longint x, y, dx, dy;
        bit [31:0] z;
        x = xi; y = yi; z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = wsps_pkg::HALF_TURN;
        end
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z = z + arc_tab[i];
            end else begin
                x -= dx; y += dy; z = z - arc_tab[i];
            end
        end
        mag = (x * GAIN_INV) >>> 24;
        ang = z;
    endfunction

    function automatic void clamp_len(inout longint x, inout longint y, input longint bound);
        longint mag;
        bit [31:0] ang;
        if (x == 0 && y == 0) return;
        measure_vec(x, y, mag, ang);
        if (mag > bound) rotate_vec(bound, ang, x, y);
    endfunction

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic bit advance_particle(input logic signed [13:0] jit);
        longint cx, cy, hx, hy, qx, qy, mag, tx, ty, sx, sy, lim, nvx, nvy;
        bit [31:0] ang;
        bit out_flag;
        bit [32:0] inward;
        cx = p_x; cy = p_y; sx = 0; sy = 0; lim = NEAR_LIMIT; out_flag = 0;
        w_ang = w_ang + 16'($signed(jit));
        if (v_x != 0 || v_y != 0) begin
            measure_vec(v_x, v_y, mag, ang);
            rotate_vec(longint'(wnd_dst), ang, hx, hy);
            cx += hx;
            cy += hy;
        end
        qx = 2 * cx - (2 * longint'(b_left) + longint'(b_width));
        qy = 2 * cy - (2 * longint'(b_top) + longint'(b_height));
        if (qx != 0 || qy != 0) begin
            measure_vec(qx, qy, mag, ang);
            if (mag > longint'(b_width)) begin
                // point the wander angle back toward the bounds centre
                inward   = {1'b0, ang + wsps_pkg::HALF_TURN} + 33'd32768;
                w_ang    = inward[31:16];
                lim      = FAR_LIMIT;
                out_flag = 1;
            end
        end
        rotate_vec(longint'(wnd_rad), {w_ang, 16'h0}, hx, hy);
        tx = cx + hx - p_x;
        ty = cy + hy - p_y;
        if (tx != 0 || ty != 0) begin
            measure_vec(tx, ty, mag, ang);
            rotate_vec(longint'(max_spd), ang, hx, hy);
            sx = hx - v_x;
            sy = hy - v_y;
            clamp_len(sx, sy, lim);
        end
        nvx = v_x + sx;
        nvy = v_y + sy;
        clamp_len(nvx, nvy, longint'(max_spd));
        v_x = sat_word(nvx);
        v_y = sat_word(nvy);
        p_x = sat_word(p_x + v_x);
        p_y = sat_word(p_y + v_y);
        return out_flag;
    endfunction

    always @(posedge clk) begin
        t_particle exp_p;
        bit        flag;
        if (!rst_n) begin
            b_left   = 0; b_top = 0; b_width = 0; b_height = 0;
            max_spd  = wsps_pkg::MAX_SPEED_RST;
            wnd_rad  = wsps_pkg::WANDER_RAD_RST;
            wnd_dst  = wsps_pkg::WANDER_DST_RST;
            p_x = 0; p_y = 0; v_x = 0; v_y = 0; w_ang = 0;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    wsps_pkg::REG_MAX_SPEED:   max_spd  = cfg_data[23:0];
                    wsps_pkg::REG_WANDER_RAD:  wnd_rad  = cfg_data[23:0];
                    wsps_pkg::REG_WANDER_DST:  wnd_dst  = cfg_data[23:0];
                    wsps_pkg::REG_BOUND_LEFT:  b_left   = cfg_data;
                    wsps_pkg::REG_BOUND_TOP:   b_top    = cfg_data;
                    wsps_pkg::REG_BOUND_WIDTH: b_width  = cfg_data[30:0];
                    wsps_pkg::REG_BOUND_HGT:   b_height = cfg_data[30:0];
                    default: ;
                endcase
            end
            // compare the result beat before predicting a new one
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result beat at %0t", $realtime);
                end else begin
                    exp_p = expected_q.pop_front();
                    if (exp_p.px !== pos_x_out || exp_p.py !== pos_y_out ||
                        exp_p.vx !== vel_x_out || exp_p.vy !== vel_y_out ||
                        exp_p.outside !== was_outside) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: mismatch at %0t exp pos %0d,%0d vel %0d,%0d out %0b",
                                     $realtime, exp_p.px, exp_p.py, exp_p.vx, exp_p.vy,
                                     exp_p.outside, "\n       got pos %0d,%0d vel %0d,%0d out %0b",
                                     pos_x_out, pos_y_out, vel_x_out, vel_y_out, was_outside);
                    end
                end
            end
            if (in_valid && !in_stall) begin
                flag = 0;
                case (func)
                    wsps_pkg::FUNC_STEP: begin
                        flag = advance_particle(theta_jitter);
                        steps_seen++;
                        if (flag) outside_seen++;
                    end
                    wsps_pkg::FUNC_LOAD_P: begin
                        p_x = value_x; p_y = value_y;
                    end
                    wsps_pkg::FUNC_LOAD_V: begin
                        v_x = value_x; v_y = value_y;
                    end
                    default: ;
                endcase
                exp_p.px = p_x[31:0]; exp_p.py = p_y[31:0];
                exp_p.vx = v_x[31:0]; exp_p.vy = v_y[31:0];
                exp_p.outside = flag;
                expected_q.push_back(exp_p);
            end
        end
        pending = expected_q.size();
    end

    initial begin
        mismatches   = 0;
        pending      = 0;
        steps_seen   = 0;
        outside_seen = 0;
    end
endmodule

// ===== tb/sv/tb_wander_steering_particle_step_unit.sv =====
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, stimulus and verdict for the particle step unit.
module tb_wander_steering_particle_step_unit;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic [1:0]         i_func = wsps_pkg::FUNC_STEP;
    logic signed [31:0] i_value_x = '0;
    logic signed [31:0] i_value_y = '0;
    logic signed [13:0] i_theta_jitter = '0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic signed [31:0] o_pos_x_out, o_pos_y_out, o_vel_x_out, o_vel_y_out;
    logic               o_was_outside;

    int  mismatches, pending, steps_seen, outside_seen;
    bit  calm = 0;
    int  items_sent = 0;

    always #6 i_clk = ~i_clk;

    wander_steering_particle_step_unit u_dut (.*);

    wsps_checker u_chk (
        .clk(i_clk), .rst_n(i_rst_n),
        .cfg_valid(i_cfg_valid), .cfg_ready(o_cfg_ready),
        .cfg_index(i_cfg_index), .cfg_data(i_cfg_data),
        .in_valid(i_in_valid), .in_stall(o_in_stall), .func(i_func),
        .value_x(i_value_x), .value_y(i_value_y), .theta_jitter(i_theta_jitter),
        .out_valid(o_out_valid), .out_stall(i_out_stall),
        .pos_x_out(o_pos_x_out), .pos_y_out(o_pos_y_out),
        .vel_x_out(o_vel_x_out), .vel_y_out(o_vel_y_out),
        .was_outside(o_was_outside),
        .mismatches(mismatches), .pending(pending),
        .steps_seen(steps_seen), .outside_seen(outside_seen)
    );

    // Receiver stall in random bursts
    always @(posedge i_clk) begin
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 5);
            i_out_stall <= 1;
            repeat (n) @(posedge i_clk);
            i_out_stall <= 0;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
    endtask

    // Drop valid, hold until every result is back, then let the block settle
    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (260) @(posedge i_clk);
    endtask

    task automatic load_setup(input logic [23:0] spd, input logic [23:0] rad,
                              input logic [23:0] dst, input logic [31:0] lft,
                              input logic [31:0] top, input logic [30:0] wid,
                              input logic [30:0] hgt);
        drain();
        write_reg(wsps_pkg::REG_MAX_SPEED, {8'h0, spd});
        write_reg(wsps_pkg::REG_WANDER_RAD, {8'h0, rad});
        write_reg(wsps_pkg::REG_WANDER_DST, {8'h0, dst});
        write_reg(wsps_pkg::REG_BOUND_LEFT, lft);
        write_reg(wsps_pkg::REG_BOUND_TOP, top);
        write_reg(wsps_pkg::REG_BOUND_WIDTH, {1'b0, wid});
        write_reg(wsps_pkg::REG_BOUND_HGT, {1'b0, hgt});
    endtask

    task automatic send_item(input logic [1:0] f, input logic [31:0] vx,
                             input logic [31:0] vy, input logic [13:0] jit);
        int n;
        i_in_valid     <= 1;
        i_func         <= f;
        i_value_x      <= vx;
        i_value_y      <= vy;
        i_theta_jitter <= jit;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 5);
            i_in_valid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] near_coord();
        if ($urandom_range(0, 15) == 0) return $urandom;
        return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endfunction

    task automatic random_item();
        int sel;
        logic [31:0] vx, vy;
        sel = $urandom_range(0, 99);
        if (sel < 85) begin
            send_item(wsps_pkg::FUNC_STEP, $urandom, $urandom, 14'($urandom));
        end else if (sel < 91) begin
            send_item(wsps_pkg::FUNC_LOAD_P, near_coord(), near_coord(), 14'($urandom));
        end else if (sel < 97) begin
            vx = ($urandom_range(0, 15) == 0) ? $urandom
                 : $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
            vy = ($urandom_range(0, 15) == 0) ? $urandom
                 : $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
            send_item(wsps_pkg::FUNC_LOAD_V, vx, vy, 14'($urandom));
        end else begin
            send_item(wsps_pkg::FUNC_NONE, $urandom, $urandom, 14'($urandom));
        end
    endtask

    initial begin
        int lim;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: defaults with zero bounds, then a contained box
        send_item(wsps_pkg::FUNC_STEP, 32'h0, 32'h0, 14'sd0);
        send_item(wsps_pkg::FUNC_LOAD_V, 32'h0001_0000, 32'h0, 14'sd0);
        send_item(wsps_pkg::FUNC_STEP, 32'h0, 32'h0, 14'h1FFF);
        send_item(wsps_pkg::FUNC_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14'h2000);
        send_item(wsps_pkg::FUNC_NONE, 32'h1234_5678, 32'h8765_4321, 14'h3FFF);
        load_setup(24'd91750, 24'd1048576, 24'd3932160, 32'hFF9C_0000, 32'hFF9C_0000,
                   31'h00C8_0000, 31'h00C8_0000);
        send_item(wsps_pkg::FUNC_LOAD_P, 32'h0, 32'h0, 14'sd0);
        send_item(wsps_pkg::FUNC_STEP, 32'h0, 32'h0, 14'sd100);
        send_item(wsps_pkg::FUNC_LOAD_P, 32'h00C8_0000, 32'hFF38_0000, 14'sd0);
        send_item(wsps_pkg::FUNC_STEP, 32'h0, 32'h0, 14'h1FFF);
        send_item(wsps_pkg::FUNC_STEP, 32'h0, 32'h0, 14'h2000);
        send_item(wsps_pkg::FUNC_LOAD_P, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 14'sd0);
        send_item(wsps_pkg::FUNC_LOAD_V, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 14'sd0);
        send_item(wsps_pkg::FUNC_STEP, 32'h0, 32'h0, 14'sd5);
        send_item(wsps_pkg::FUNC_LOAD_P, 32'h8000_0000, 32'h8000_0000, 14'sd0);
        send_item(wsps_pkg::FUNC_LOAD_V, 32'h8000_0000, 32'h8000_0000, 14'sd0);
        send_item(wsps_pkg::FUNC_STEP, 32'h0, 32'h0, 14'sd0);
        load_setup(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_item(wsps_pkg::FUNC_LOAD_V, 32'h0100_0000, 32'hFF00_0000, 14'sd0);
        send_item(wsps_pkg::FUNC_STEP, 32'h0, 32'h0, 14'h1555);
        send_item(wsps_pkg::FUNC_STEP, 32'h0, 32'h0, 14'h2AAA);
        load_setup(24'd0, 24'd0, 24'd0, 32'h0, 32'h0, 31'h0, 31'h0);
        send_item(wsps_pkg::FUNC_STEP, 32'h0, 32'h0, 14'sd7);
        send_item(wsps_pkg::FUNC_LOAD_V, 32'h0002_0000, 32'h0002_0000, 14'sd0);
        send_item(wsps_pkg::FUNC_STEP, 32'h0, 32'h0, 14'sd7);

        // Random phases over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) calm = 1;
            case (ph)
                0: load_setup(24'd91750, 24'd1048576, 24'd3932160, 32'hFF9C_0000,
                              32'hFF9C_0000, 31'h00C8_0000, 31'h00C8_0000);
                1: load_setup(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'h8000_0000,
                              32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
                2: load_setup(24'd0, 24'd0, 24'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              31'h0, 31'h0);
                default: load_setup(24'($urandom_range(0, 24'h06_0000)), 24'($urandom),
                                    24'($urandom), $signed($urandom_range(0, 32'h0100_0000))
                                    - 32'sh0080_0000, near_coord(),
                                    31'($urandom_range(0, 31'h0200_0000)), 31'($urandom));
            endcase
            lim = (ph == 7) ? 260 : 235;
            for (int k = 0; k < lim; k++) begin
                // let the whole pipe empty once mid phase
                if (ph == 3 && k == 100) drain();
                random_item();
            end
        end
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        $display("Run covered %0d items, %0d steps with %0d containment turns,",
                 items_sent, steps_seen, outside_seen);
        $display("over several register settings including zero and full-scale values.");
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
